@@ design/dss_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package dss_pkg;

    localparam int REQ_DEPTH   = 512;
    localparam int TRACK_COUNT = 2048;
    localparam int IDX_W       = $clog2(REQ_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int TRK_W       = 11;
    localparam int TOT_W       = 20;
    localparam int ENT_W       = TRK_W + 1;
    localparam int CFG_W       = 11;
    localparam int S_DATA_W    = 16;
    localparam int M_DATA_W    = 48;

    localparam logic [TOT_W-1:0] TOTAL_MAX = {TOT_W{1'b1}};

    localparam logic REG_MODE  = 1'b0;
    localparam logic REG_START = 1'b1;

    localparam logic REQ_ADD   = 1'b0;
    localparam logic REQ_FETCH = 1'b1;

    typedef enum logic [1:0] {
        MODE_FCFS  = 2'd0,
        MODE_SSTF  = 2'd1,
        MODE_LOOK  = 2'd2,
        MODE_CSCAN = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PICK
    } state_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
        logic [TRK_W-1:0] trk;
    } cand_t;

    function automatic logic [TRK_W-1:0] clamp_track(input logic [TRK_W-1:0] t);
        logic [TRK_W-1:0] r;
        r = t;
        if (32'(t) >= TRACK_COUNT) begin
            r = TRK_W'(TRACK_COUNT - 1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ design/disk_seek_scheduler.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  transaction                      fields
// s_        in         add or fetch request             tuser: req_type, tdata: track
// m_        out        one per fetch                    tdata: track, seek, total;
//                                                       tuser: queue_empty, tlast: batch_done
// cfg_      in         register write, no read-back     0 sched_mode, 1 start_track
//
// In a fetch every stored entry is read from the request RAM one per cycle
// (single read port) and the pending ones are fed through one candidate compare
// stage; an empty fetch skips the scan and goes straight to the result.
// Reset is synchronous on aresetn; the request RAM needs no clearing.
// s_tready is low while a fetch is in progress or its result cannot be loaded
// because m_ holds an untaken transaction.

module disk_seek_scheduler (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire  [dss_pkg::S_DATA_W-1:0]      s_tdata,   // [10:0] track
    input  wire                               s_tuser,   // [0] req_type
    output logic                              m_tvalid,
    input  wire                               m_tready,
    output logic [dss_pkg::M_DATA_W-1:0]      m_tdata,   // [10:0] served_track,
                                                         // [21:11] seek_distance,
                                                         // [41:22] total_distance
    output logic                              m_tuser,   // [0] queue_empty
    output logic                              m_tlast,   // batch_done
    input  wire                               cfg_wr_en,
    input  wire                               cfg_index,
    input  wire  [dss_pkg::CFG_W-1:0]         cfg_wdata
);
    import dss_pkg::*;

    state_t state_reg, state_next;

    mode_t            mode_reg;
    logic [TRK_W-1:0] start_reg;

    logic [ENT_W-1:0] mem [REQ_DEPTH];
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [ENT_W-1:0] mem_wdata;
    logic [ENT_W-1:0] rd_data_reg;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] arrival_reg;
    logic [TRK_W-1:0] head_reg;
    logic [TOT_W-1:0] total_reg;
    logic             phase_reg;
    logic             fetch_empty_reg;

    logic [CNT_W-1:0] rd_idx_reg;
    logic [CNT_W-1:0] rd_pos_reg;
    logic             rd_valid_reg;

    cand_t first_reg, first_next;
    cand_t sstf_reg,  sstf_next;
    cand_t up_reg,    up_next;
    cand_t dn_reg,    dn_next;
    cand_t min_reg,   min_next;
    logic [TRK_W-1:0] best_d_reg, best_d_next;
    logic             zero_reg,   zero_next;

    logic             m_valid_reg;
    logic [TRK_W-1:0] res_trk_reg;
    logic [TRK_W-1:0] res_dist_reg;
    logic [TOT_W-1:0] res_total_reg;
    logic             res_empty_reg;
    logic             res_done_reg;

    logic             in_acc;
    logic             fetch_acc;
    logic             out_free;
    logic             load_res;
    logic             ent_pend;
    logic [TRK_W-1:0] ent_trk;
    logic [IDX_W-1:0] ent_idx;
    logic [TRK_W-1:0] ent_dist;
    logic             scan_last;
    logic             is_empty;

    cand_t            pick;
    logic             from_zero;
    logic             phase_next;
    logic [TRK_W-1:0] from_trk;
    logic [TRK_W-1:0] pick_dist;
    logic [TOT_W:0]   sum;
    logic [TOT_W-1:0] total_next;
    logic [CNT_W-1:0] arrival_inc;
    logic             done_now;

    assign in_acc    = s_tvalid && s_tready;
    assign fetch_acc = in_acc && s_tuser == REQ_FETCH;
    assign out_free  = !m_valid_reg || m_tready;
    assign load_res  = (state_reg == ST_PICK) && out_free;
    assign is_empty  = arrival_reg >= count_reg;

    assign ent_pend  = rd_data_reg[TRK_W];
    assign ent_trk   = rd_data_reg[TRK_W-1:0];
    assign ent_idx   = rd_pos_reg[IDX_W-1:0];
    assign ent_dist  = (head_reg >= ent_trk) ? head_reg - ent_trk : ent_trk - head_reg;
    assign scan_last = rd_valid_reg && (rd_pos_reg == count_reg - CNT_W'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (in_acc && s_tuser == REQ_FETCH) begin
                    state_next = is_empty ? ST_PICK : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // candidate compare stage, one RAM entry per cycle
    always_comb begin
        first_next  = first_reg;
        sstf_next   = sstf_reg;
        up_next     = up_reg;
        dn_next     = dn_reg;
        min_next    = min_reg;
        best_d_next = best_d_reg;
        zero_next   = zero_reg;
        if (rd_valid_reg && ent_pend) begin
            if (!first_reg.found) begin
                first_next = '{found: 1'b1, idx: ent_idx, trk: ent_trk};
            end
            if (!zero_reg) begin
                if (ent_dist == '0) begin
                    zero_next = 1'b1;
                    sstf_next = '{found: 1'b1, idx: ent_idx, trk: ent_trk};
                end else if (!sstf_reg.found || ent_dist <= best_d_reg) begin
                    best_d_next = ent_dist;
                    sstf_next   = '{found: 1'b1, idx: ent_idx, trk: ent_trk};
                end
            end
            if (ent_trk >= head_reg && (!up_reg.found || ent_trk < up_reg.trk)) begin
                up_next = '{found: 1'b1, idx: ent_idx, trk: ent_trk};
            end
            if (ent_trk <= head_reg && (!dn_reg.found || ent_trk > dn_reg.trk)) begin
                dn_next = '{found: 1'b1, idx: ent_idx, trk: ent_trk};
            end
            if (!min_reg.found || ent_trk < min_reg.trk) begin
                min_next = '{found: 1'b1, idx: ent_idx, trk: ent_trk};
            end
        end
        if (fetch_acc) begin
            first_next = '0;
            sstf_next  = '0;
            up_next    = '0;
            dn_next    = '0;
            min_next   = '0;
            zero_next  = 1'b0;
        end
    end

    always_comb begin
        pick       = first_reg;
        from_zero  = 1'b0;
        phase_next = phase_reg;
        case (mode_reg)
            MODE_FCFS: pick = first_reg;
            MODE_SSTF: pick = sstf_reg;
            MODE_LOOK: begin
                if (!phase_reg) begin
                    if (up_reg.found) begin
                        pick = up_reg;
                    end else begin
                        pick       = dn_reg;
                        phase_next = 1'b1;
                    end
                end else begin
                    if (dn_reg.found) begin
                        pick = dn_reg;
                    end else begin
                        pick       = up_reg;
                        phase_next = 1'b0;
                    end
                end
            end
            MODE_CSCAN: begin
                if (up_reg.found) begin
                    pick = up_reg;
                end else begin
                    pick       = min_reg;
                    from_zero  = 1'b1;
                    phase_next = 1'b1;
                end
            end
            default: pick = first_reg;
        endcase
        from_trk    = from_zero ? '0 : head_reg;
        pick_dist   = (from_trk >= pick.trk) ? from_trk - pick.trk : pick.trk - from_trk;
        sum         = {1'b0, total_reg} + (TOT_W + 1)'(pick_dist);
        total_next  = sum[TOT_W] ? TOTAL_MAX : sum[TOT_W-1:0];
        arrival_inc = arrival_reg + CNT_W'(1);
        done_now    = arrival_inc >= count_reg;
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = count_reg[IDX_W-1:0];
        mem_wdata = {1'b1, clamp_track(s_tdata[TRK_W-1:0])};
        if (state_reg == ST_IDLE && in_acc && s_tuser == REQ_ADD
                && count_reg < CNT_W'(REQ_DEPTH)) begin
            mem_we = 1'b1;
        end else if (load_res && !fetch_empty_reg) begin
            mem_we    = 1'b1;
            mem_waddr = pick.idx;
            mem_wdata = {1'b0, pick.trk};
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_idx_reg[IDX_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= MODE_FCFS;
            start_reg       <= '0;
            count_reg       <= '0;
            arrival_reg     <= '0;
            head_reg        <= '0;
            total_reg       <= '0;
            phase_reg       <= 1'b0;
            fetch_empty_reg <= 1'b0;
            rd_idx_reg      <= '0;
            rd_pos_reg      <= '0;
            rd_valid_reg    <= 1'b0;
            first_reg       <= '0;
            sstf_reg        <= '0;
            up_reg          <= '0;
            dn_reg          <= '0;
            min_reg         <= '0;
            best_d_reg      <= '0;
            zero_reg        <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_MODE:  mode_reg  <= mode_t'(cfg_wdata[1:0]);
                    REG_START: start_reg <= clamp_track(cfg_wdata[TRK_W-1:0]);
                    default: ;
                endcase
            end

            if (m_valid_reg && m_tready && !load_res) begin
                m_valid_reg <= 1'b0;
            end

            first_reg  <= first_next;
            sstf_reg   <= sstf_next;
            up_reg     <= up_next;
            dn_reg     <= dn_next;
            min_reg    <= min_next;
            best_d_reg <= best_d_next;
            zero_reg   <= zero_next;

            case (state_reg)
                ST_IDLE: begin
                    rd_idx_reg   <= '0;
                    rd_valid_reg <= 1'b0;
                    if (in_acc) begin
                        if (s_tuser == REQ_ADD) begin
                            if (count_reg < CNT_W'(REQ_DEPTH)) begin
                                count_reg <= count_reg + CNT_W'(1);
                            end
                        end else begin
                            fetch_empty_reg <= is_empty;
                            if (!is_empty && arrival_reg == '0) begin
                                head_reg  <= start_reg;
                                total_reg <= '0;
                                phase_reg <= 1'b0;
                            end
                        end
                    end
                end
                ST_SCAN: begin
                    rd_valid_reg <= rd_idx_reg < count_reg;
                    if (rd_idx_reg < count_reg) begin
                        rd_pos_reg   <= rd_idx_reg;
                        rd_idx_reg   <= rd_idx_reg + CNT_W'(1);
                    end
                end
                ST_PICK: begin
                    rd_valid_reg <= 1'b0;
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        if (fetch_empty_reg) begin
                            res_trk_reg   <= '0;
                            res_dist_reg  <= '0;
                            res_total_reg <= total_reg;
                            res_empty_reg <= 1'b1;
                            res_done_reg  <= 1'b0;
                        end else begin
                            res_trk_reg   <= pick.trk;
                            res_dist_reg  <= pick_dist;
                            res_total_reg <= total_next;
                            res_empty_reg <= 1'b0;
                            res_done_reg  <= done_now;
                            head_reg      <= pick.trk;
                            total_reg     <= total_next;
                            phase_reg     <= phase_next;
                            if (done_now) begin
                                count_reg   <= '0;
                                arrival_reg <= '0;
                            end else begin
                                arrival_reg <= arrival_inc;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W - 2 * TRK_W - TOT_W){1'b0}},
                       res_total_reg, res_dist_reg, res_trk_reg};
    assign m_tuser  = res_empty_reg;
    assign m_tlast  = res_done_reg;

    a_arrival_le_count: assert property (@(posedge aclk) disable iff (!aresetn)
        arrival_reg <= count_reg)
        else $error("served count exceeds stored count");

    a_add_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && s_tuser == REQ_ADD && count_reg < CNT_W'(REQ_DEPTH))
        |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("accepted add did not grow the store");

    a_pick_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PICK && !fetch_empty_reg) |-> (first_reg.found && pick.found))
        else $error("fetch finished its scan without a pending entry");

    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && res_empty_reg)
        |-> (res_trk_reg == '0 && res_dist_reg == '0 && !res_done_reg))
        else $error("empty fetch result carries a track");

endmodule

`default_nettype wire
